>>> src/azg_pkg.sv
// ----------------------------------------------------------------------------
// azg_pkg: shared types and constants for the azimuthal gap block
// Store geometry, angle constants, controller command and status bundles.
// ----------------------------------------------------------------------------
package azg_pkg;

  // Store capacity and derived widths
  localparam int unsigned MaxAzimuths = 64;
  localparam int unsigned AddrW       = $clog2(MaxAzimuths);
  localparam int unsigned CountW      = $clog2(MaxAzimuths + 1);

  // Angles in hundredths of a degree
  localparam int unsigned AzW        = 16;
  localparam int unsigned GapW       = 17;
  localparam logic [AzW-1:0]  AzMax      = 16'd35999;
  localparam logic [GapW-1:0] FullCircle = 17'd36000;

  // Output field widths
  localparam int unsigned CountFieldW = 7;
  localparam int unsigned OutDataW    = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;   // capture the accepted transaction
    logic set_drop;    // store full, mark the azimuth as dropped
    logic ins_start;   // insertion pointer starts at the fill count
    logic ins_read;    // read the entry below the insertion pointer
    logic ins_shift;   // move that entry up one place, pointer down
    logic ins_place;   // write the azimuth at the pointer, count up
    logic gap_init;    // clear the running maximum and the scan index
    logic gap_read;    // read the entry at the scan index
    logic gap_acc;     // fold the read entry into the running maximum
    logic wrap;        // fold in the wrap-around gap
    logic emit;        // load the result register, clear the set
  } azg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic present;     // captured item carries an azimuth
    logic last;        // captured item closes the set
    logic full;        // store holds MaxAzimuths entries
    logic pos_zero;    // insertion pointer at the bottom
    logic greater;     // read entry is above the new azimuth
    logic count_zero;  // store is empty
    logic idx_final;   // scan index is on the highest entry
    logic out_free;    // result register can take a new result
  } azg_sts_t;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    StIdle    = 8'b0000_0001,
    StDecode  = 8'b0000_0010,
    StInsChk  = 8'b0000_0100,
    StInsCmp  = 8'b0000_1000,
    StGapInit = 8'b0001_0000,
    StGapRd   = 8'b0010_0000,
    StGapAcc  = 8'b0100_0000,
    StWrap    = 8'b1000_0000
  } azg_state_e;

endpackage

>>> src/azimuthal_gap.sv
// ----------------------------------------------------------------------------
// azimuthal_gap: largest azimuthal gap of a set of station azimuths
// Sorted-insertion store with a gap scan, controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one station azimuth per transaction in hundredths of a
//   degree; tuser says whether the transaction carries an azimuth, tlast
//   closes the set. Azimuths above 35999 are saturated.
//   m_axis returns one transaction per closed set: the largest gap (with
//   the wrap-around gap), the number of stored azimuths and an overflow
//   flag for azimuths dropped once the 64-entry store is full.
// Insertion and scan:
//   An azimuth is inserted by moving each stored entry above it up one
//   place; the store's single write port and registered read make each
//   move a read step followed by a write step. Closing a set runs a scan
//   over the stored entries, one registered read and one compare per
//   entry, then folds in the wrap-around gap; an empty set skips the scan.
// Reset clears the fill count, the overflow flag and the output valid flag;
//   the store itself needs no clearing. A stalled receiver holds the result
//   in the output register; new azimuths are still taken until the next
//   result is ready, which then waits for the register to drain.
// ----------------------------------------------------------------------------
module azimuthal_gap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] azimuth
  input  logic        s_axis_tuser,   // [0] present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] max_gap, [22:16] count, [23] zero
  output logic        m_axis_tuser    // [0] overflow
);

  azg_pkg::azg_cmd_t cmd;
  azg_pkg::azg_sts_t sts;
  logic [azg_pkg::AzW-1:0]         out_gap;
  logic [azg_pkg::CountFieldW-1:0] out_count;

  // Sequencer
  azg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store, scan and result register
  azg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .az_i           (s_axis_tdata),
    .present_i      (s_axis_tuser),
    .last_i         (s_axis_tlast),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_gap_o      (out_gap),
    .out_count_o    (out_count),
    .out_overflow_o (m_axis_tuser)
  );

  // Pack the result fields
  assign m_axis_tdata = {1'b0, out_count, out_gap};

endmodule

>>> src/azg_ctrl.sv
// ----------------------------------------------------------------------------
// azg_ctrl: sequencer for the azimuthal gap block
// Steps sorted insertion, the gap scan and the result hand-off.
// ----------------------------------------------------------------------------
module azg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  azg_pkg::azg_sts_t sts_i,
  output azg_pkg::azg_cmd_t cmd_o
);

  azg_pkg::azg_state_e state_q, state_d;
  logic                emit_wait_q, emit_wait_d;

  // Input is taken only between items
  assign in_ready_o = (state_q == azg_pkg::StIdle) && !emit_wait_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    emit_wait_d = emit_wait_q;
    cmd_o       = '0;
    if (emit_wait_q) begin
      // result ready, wait for room in the output register
      if (sts_i.out_free) begin
        cmd_o.emit  = 1'b1;
        emit_wait_d = 1'b0;
        state_d     = azg_pkg::StIdle;
      end
    end else begin
      unique case (state_q)
        azg_pkg::StIdle: begin
          if (in_valid_i) begin
            cmd_o.load_item = 1'b1;
            state_d         = azg_pkg::StDecode;
          end
        end
        azg_pkg::StDecode: begin
          priority if (sts_i.present && sts_i.full) begin
            cmd_o.set_drop = 1'b1;
            state_d = sts_i.last ? azg_pkg::StGapInit : azg_pkg::StIdle;
          end else if (sts_i.present) begin
            cmd_o.ins_start = 1'b1;
            state_d         = azg_pkg::StInsChk;
          end else if (sts_i.last) begin
            state_d = azg_pkg::StGapInit;
          end else begin
            state_d = azg_pkg::StIdle;
          end
        end
        azg_pkg::StInsChk: begin
          if (sts_i.pos_zero) begin
            cmd_o.ins_place = 1'b1;
            state_d = sts_i.last ? azg_pkg::StGapInit : azg_pkg::StIdle;
          end else begin
            cmd_o.ins_read = 1'b1;
            state_d        = azg_pkg::StInsCmp;
          end
        end
        azg_pkg::StInsCmp: begin
          if (sts_i.greater) begin
            cmd_o.ins_shift = 1'b1;
            state_d         = azg_pkg::StInsChk;
          end else begin
            cmd_o.ins_place = 1'b1;
            state_d = sts_i.last ? azg_pkg::StGapInit : azg_pkg::StIdle;
          end
        end
        azg_pkg::StGapInit: begin
          cmd_o.gap_init = 1'b1;
          if (sts_i.count_zero) begin
            emit_wait_d = 1'b1;
          end else begin
            state_d = azg_pkg::StGapRd;
          end
        end
        azg_pkg::StGapRd: begin
          cmd_o.gap_read = 1'b1;
          state_d        = azg_pkg::StGapAcc;
        end
        azg_pkg::StGapAcc: begin
          cmd_o.gap_acc = 1'b1;
          state_d = sts_i.idx_final ? azg_pkg::StWrap : azg_pkg::StGapRd;
        end
        azg_pkg::StWrap: begin
          cmd_o.wrap  = 1'b1;
          emit_wait_d = 1'b1;
        end
        default: begin
          state_d = azg_pkg::StIdle;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= azg_pkg::StIdle;
      emit_wait_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_wait_q <= emit_wait_d;
    end
  end

endmodule

>>> src/azg_dp.sv
// ----------------------------------------------------------------------------
// azg_dp: datapath of the azimuthal gap block
// Sorted azimuth store, insertion pointer, gap scan and result register.
// ----------------------------------------------------------------------------
module azg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [azg_pkg::AzW-1:0]           az_i,
  input  logic                              present_i,
  input  logic                              last_i,
  input  azg_pkg::azg_cmd_t                 cmd_i,
  output azg_pkg::azg_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [azg_pkg::AzW-1:0]           out_gap_o,
  output logic [azg_pkg::CountFieldW-1:0]   out_count_o,
  output logic                              out_overflow_o
);

  // Sorted store
  logic [azg_pkg::AzW-1:0]    mem_q [azg_pkg::MaxAzimuths];
  logic [azg_pkg::AzW-1:0]    rdata_q;
  logic [azg_pkg::AddrW-1:0]  rd_addr;
  logic                       wr_en;
  logic [azg_pkg::AddrW-1:0]  wr_addr;
  logic [azg_pkg::AzW-1:0]    wr_data;

  // Item and scan registers
  logic [azg_pkg::AzW-1:0]    az_q;
  logic                       present_q, last_q;
  logic [azg_pkg::CountW-1:0] count_q, pos_q, idx_q;
  logic                       drop_q;
  logic [azg_pkg::AzW-1:0]    first_q, prev_q;
  logic [azg_pkg::GapW-1:0]   best_q;
  logic [azg_pkg::GapW-1:0]   step_gap, wrap_gap;
  logic [azg_pkg::CountW-1:0] pos_dn, idx_up;

  // Result register
  logic                       out_valid_q;
  logic [azg_pkg::AzW-1:0]    out_gap_q;
  logic [azg_pkg::CountFieldW-1:0] out_count_q;
  logic                       out_overflow_q;

  assign pos_dn = pos_q - azg_pkg::CountW'(1);
  assign idx_up = idx_q + azg_pkg::CountW'(1);

  // Memory port selection
  assign rd_addr = cmd_i.ins_read ? pos_dn[azg_pkg::AddrW-1:0] : idx_q[azg_pkg::AddrW-1:0];
  assign wr_en   = cmd_i.ins_shift || cmd_i.ins_place;
  assign wr_addr = pos_q[azg_pkg::AddrW-1:0];
  assign wr_data = cmd_i.ins_shift ? rdata_q : az_q;

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.ins_read || cmd_i.gap_read) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Neighbor gap and wrap-around gap
  assign step_gap = {1'b0, rdata_q} - {1'b0, prev_q};
  assign wrap_gap = azg_pkg::FullCircle - {1'b0, prev_q} + {1'b0, first_q};

  // Item capture, insertion pointer, gap scan (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      az_q      <= (az_i > azg_pkg::AzMax) ? azg_pkg::AzMax : az_i;
      present_q <= present_i;
      last_q    <= last_i;
    end
    if (cmd_i.ins_start) begin
      pos_q <= count_q;
    end else if (cmd_i.ins_shift) begin
      pos_q <= pos_dn;
    end
    if (cmd_i.gap_init) begin
      idx_q  <= '0;
      best_q <= '0;
    end else if (cmd_i.gap_acc) begin
      idx_q  <= idx_up;
      prev_q <= rdata_q;
      if (idx_q == '0) begin
        first_q <= rdata_q;
      end else if (step_gap > best_q) begin
        best_q <= step_gap;
      end
    end else if (cmd_i.wrap) begin
      if (wrap_gap > best_q) begin
        best_q <= wrap_gap;
      end
    end
    if (cmd_i.emit) begin
      out_gap_q      <= best_q[azg_pkg::AzW-1:0];
      out_count_q    <= azg_pkg::CountFieldW'(count_q);
      out_overflow_q <= drop_q;
    end
  end

  // Set bookkeeping and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        if (cmd_i.ins_place) begin
          count_q <= count_q + azg_pkg::CountW'(1);
        end
        if (cmd_i.set_drop) begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.present    = present_q;
    sts_o.last       = last_q;
    sts_o.full       = (count_q >= azg_pkg::CountW'(azg_pkg::MaxAzimuths));
    sts_o.pos_zero   = (pos_q == '0);
    sts_o.greater    = (rdata_q > az_q);
    sts_o.count_zero = (count_q == '0);
    sts_o.idx_final  = (idx_up == count_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_gap_o      = out_gap_q;
  assign out_count_o    = out_count_q;
  assign out_overflow_o = out_overflow_q;

  // Fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= azg_pkg::CountW'(azg_pkg::MaxAzimuths))
    else $error("fill count above capacity");

  // A placement grows the set by exactly one
  a_place_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_place |=> count_q == $past(count_q) + azg_pkg::CountW'(1))
    else $error("placement did not advance the fill count");

  // A shift never happens at the bottom of the store
  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_shift |-> pos_q != '0)
    else $error("shift with insertion pointer at zero");

  // An emitted result is presented and the set is cleared
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && count_q == '0 && !drop_q)
    else $error("result not presented or set not cleared");

  // Gaps stay within a full circle
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> best_q <= azg_pkg::FullCircle)
    else $error("gap above full circle");

endmodule

>>> tb/azg_gap_checker.sv
// ----------------------------------------------------------------------------
// azg_gap_checker: result predictor and comparator for azimuthal_gap
// Follows every accepted azimuth transaction, keeps its own sorted copy of
// the set, works out the largest gap when a set closes and compares each
// accepted result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module azg_gap_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [azg_pkg::AzW-1:0]      s_axis_tdata,   // [15:0] azimuth
  input  logic                         s_axis_tuser,   // [0] present
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [azg_pkg::OutDataW-1:0] m_axis_tdata,   // [15:0] max_gap, [22:16] count, [23] zero
  input  logic                         m_axis_tuser,   // [0] overflow
  output int unsigned                  err_count_o,
  output int unsigned                  pending_o
);

  // One closed set as the block should report it
  typedef struct packed {
    logic [azg_pkg::AzW-1:0]         max_gap;
    logic [azg_pkg::CountFieldW-1:0] count;
    logic                            overflow;
  } gap_result_t;

  logic [azg_pkg::AzW-1:0] sorted_az[$];    // current set, ascending
  logic           az_dropped;      // store overflowed in current set
  gap_result_t    expected_gaps[$];
  gap_result_t    oldest_gap;
  int unsigned    err_cnt = 0;

  assign err_count_o = err_cnt;

  // Printing is capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < 100) begin
      $display("%0t gap checker: %s: got %0d, expected %0d", $time, what, got, want);
    end
    err_cnt++;
  endtask

  // Sorted insertion with saturation; full store drops and flags
  function automatic void store_azimuth(input logic [azg_pkg::AzW-1:0] az_raw);
    logic [azg_pkg::AzW-1:0] az;
    int unsigned    pos;
    az = (az_raw > azg_pkg::AzMax) ? azg_pkg::AzMax : az_raw;
    if (sorted_az.size() >= azg_pkg::MaxAzimuths) begin
      az_dropped = 1'b1;
      return;
    end
    pos = sorted_az.size();
    while (pos > 0 && sorted_az[pos-1] > az) pos--;
    sorted_az.insert(pos, az);
  endfunction

  // Largest neighbor gap including wrap-around, then start a fresh set
  function automatic gap_result_t close_set();
    gap_result_t res;
    int unsigned best;
    int unsigned gap;
    int unsigned n;
    n    = sorted_az.size();
    best = 0;
    if (n != 0) begin
      for (int unsigned i = 1; i < n; i++) begin
        gap = 32'(sorted_az[i]) - 32'(sorted_az[i-1]);
        if (gap > best) best = gap;
      end
      gap = 32'(azg_pkg::FullCircle) - 32'(sorted_az[n-1]) + 32'(sorted_az[0]);
      if (gap > best) best = gap;
    end
    res.max_gap  = best[azg_pkg::AzW-1:0];
    res.count    = n[azg_pkg::CountFieldW-1:0];
    res.overflow = az_dropped;
    sorted_az.delete();
    az_dropped = 1'b0;
    return res;
  endfunction

  // Sample both channels at the edge where transactions complete
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_az.delete();
      expected_gaps.delete();
      az_dropped = 1'b0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_gaps.size() == 0) begin
          report_mismatch("result with no set pending", 32'(m_axis_tdata[15:0]), 0);
        end else begin
          oldest_gap = expected_gaps.pop_front();
          if (m_axis_tdata[15:0] !== oldest_gap.max_gap)
            report_mismatch("max_gap", 32'(m_axis_tdata[15:0]),
                            32'(oldest_gap.max_gap));
          if (m_axis_tdata[22:16] !== oldest_gap.count)
            report_mismatch("count", 32'(m_axis_tdata[22:16]), 32'(oldest_gap.count));
          if (m_axis_tdata[23] !== 1'b0)
            report_mismatch("pad bit", 32'(m_axis_tdata[23]), 0);
          if (m_axis_tuser !== oldest_gap.overflow)
            report_mismatch("overflow", 32'(m_axis_tuser), 32'(oldest_gap.overflow));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) store_azimuth(s_axis_tdata);
        if (s_axis_tlast) expected_gaps.push_back(close_set());
      end
      pending_o <= expected_gaps.size();
    end
  end

endmodule

>>> tb/azimuthal_gap_test.sv
// ----------------------------------------------------------------------------
// azimuthal_gap_test: top-level testbench for azimuthal_gap
// Drives azimuth sets (directed corner cases, then random sets of mixed
// size with noise, overflow and back-pressure) and leaves prediction and
// comparison to azg_gap_checker.
// ----------------------------------------------------------------------------
module azimuthal_gap_test;

  localparam int unsigned ItemTarget    = 1050;
  localparam int unsigned TailItems     = 150;   // final stretch without idling
  localparam int unsigned HoldSet       = 20;    // long receiver hold-off here
  localparam int unsigned PauseSet      = 45;    // sender drains the block here
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainCycles   = 300;   // worst insert plus worst scan
  localparam int unsigned WatchdogLimit = 5000;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [azg_pkg::AzW-1:0]      s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [azg_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned sent_items    = 0;
  int unsigned stall_cycles  = 0;
  logic [azg_pkg::AzW-1:0] prev_az = '0;
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  bit          sink_hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  azimuthal_gap u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  azg_gap_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (fail_count),
    .pending_o     (results_pending)
  );

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request
  initial begin : result_sink
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One azimuth transaction, with an optional idle burst in front
  task automatic send_item(input logic [azg_pkg::AzW-1:0] az, input logic present,
                           input logic last);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= az;
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (present || last) sent_items++;
  endtask

  // Mostly in-range angles, some clustered, repeated, extreme or saturating
  function automatic logic [azg_pkg::AzW-1:0] pick_azimuth(input int unsigned base);
    int unsigned             r;
    logic [azg_pkg::AzW-1:0] az;
    r = $urandom_range(0, 19);
    if (r == 0)      az = azg_pkg::AzW'($urandom_range(36000, 65535));
    else if (r == 1) az = '0;
    else if (r == 2) az = azg_pkg::AzMax;
    else if (r == 3) az = prev_az;
    else if (r < 10) az = azg_pkg::AzW'((base + $urandom_range(0, 400)) % 36000);
    else             az = azg_pkg::AzW'($urandom_range(0, 35999));
    prev_az = az;
    return az;
  endfunction

  // A set of n_az azimuths, closed either on the last one or by an empty item
  task automatic send_set(input int unsigned n_az);
    int unsigned base;
    bit          empty_close;
    base        = $urandom_range(0, 35999);
    empty_close = (n_az == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n_az; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(azg_pkg::AzW'($urandom), 1'b0, 1'b0);
      send_item(pick_azimuth(base), 1'b1, !empty_close && (i == n_az - 1));
    end
    if (empty_close) send_item(azg_pkg::AzW'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  initial begin : stimulus
    int unsigned set_no;
    int unsigned r;
    set_no = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty set, then single azimuths at both ends of the range
    send_item('0, 1'b0, 1'b1);
    send_item('0, 1'b1, 1'b1);
    send_item(azg_pkg::AzMax, 1'b1, 1'b1);
    // Both extremes together: tiny wrap gap, huge inner gap
    send_item('0, 1'b1, 1'b0);
    send_item(azg_pkg::AzMax, 1'b1, 1'b1);
    // Equal azimuths stay separate entries
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'd100, 1'b1, 1'b1);
    // Ignored item, saturating angles, closing item without an azimuth
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'd36000, 1'b1, 1'b0);
    send_item(16'd1, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b1);
    // Out-of-order arrival, then alternating bit patterns
    send_item(16'd18000, 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'd27000, 1'b1, 1'b0);
    send_item(16'd9000, 1'b1, 1'b1);
    send_item(16'h5555, 1'b1, 1'b0);
    send_item(16'h2AAA, 1'b1, 1'b1);

    // Store exactly full, then overflowing
    send_set(azg_pkg::MaxAzimuths);
    send_set(azg_pkg::MaxAzimuths + 6);

    // Random sets, mostly small
    while (sent_items < ItemTarget) begin
      if (sent_items + TailItems >= ItemTarget) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      if (set_no == HoldSet) begin
        // Receiver holds off while short sets keep coming: input must stall
        sink_hold_req = 1'b1;
        tx_idle_on    = 1'b0;
        repeat (8) send_set($urandom_range(1, 3));
      end else if (set_no == PauseSet) begin
        wait_results_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 5)       send_set(0);
      else if (r < 60) send_set($urandom_range(1, 4));
      else if (r < 90) send_set($urandom_range(5, 12));
      else if (r < 98) send_set($urandom_range(13, 40));
      else             send_set($urandom_range(60, 70));
      set_no++;
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
